// ===== hdl/rqms_pkg.sv =====
// ----------------------------------------------------------------------------
// rqms_pkg
// Shared types and constants for the ready queue with minimum select.
// ----------------------------------------------------------------------------
`default_nettype none
package rqms_pkg;
  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_ENQ = 3'd0, REQ_FIFO = 3'd1, REQ_REMOVE = 3'd2,
    REQ_SHORT = 3'd3, REQ_PRIO = 3'd4, REQ_TICK = 3'd5
  } req_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [15:0] waited;
  } slot_t;

  typedef struct packed {
    logic       start;     // latch request, reset scan
    logic       scan;      // evaluate entry at scan offset
    logic       sel;       // load offset of selected entry
    logic       shift;     // move entry offset+1 into offset
    logic       finish;    // commit result
  } cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       empty;
    logic       scan_last;  // scan offset is last entry
    logic       shift_last; // shift offset+1 is last entry
    logic       match;      // entry at scan offset has the requested id
    logic       need_shift; // selected entry sits between head and tail
  } stat_t;
endpackage
`default_nettype wire

// ===== hdl/rqms_datapath.sv =====
// ----------------------------------------------------------------------------
// rqms_datapath
// Entry store, scan/shift pointers, minimum tracking and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module rqms_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rqms_pkg::cmd_t cmd,
  output rqms_pkg::stat_t     stat,
  input  wire logic [2:0]     req_type,
  input  wire logic [7:0]     process_id,
  input  wire logic [15:0]    remaining_in,
  input  wire logic [7:0]     priority_in,
  input  wire logic [15:0]    waited_in,
  output logic [1:0]          r_status,
  output logic                r_taken_valid,
  output rqms_pkg::slot_t     r_taken,
  output logic [4:0]          r_occupancy
);
  import rqms_pkg::*;

  slot_t         mem [DEPTH];
  slot_t         cur;
  slot_t         nxt_e;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic [CW-1:0] off;
  logic [CW-1:0] best;
  logic [15:0]   best_key;
  logic [15:0]   key;
  logic          found;
  logic [2:0]    req;
  slot_t         in_e;
  logic [7:0]    pid;
  slot_t         best_e;

  function automatic logic [AW-1:0] slot_of(logic [AW-1:0] h, logic [CW-1:0] o);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, o};
    return s[AW-1:0];
  endfunction

  always_comb cur = mem[slot_of(head, off)];
  always_comb nxt_e = mem[slot_of(head, off + CW'(1))];
  always_comb key = (req == REQ_PRIO) ? {8'd0, cur.prio} : cur.remaining;

  always_comb begin
    stat.req = req;
    stat.empty = (count == '0);
    stat.scan_last = ((off + CW'(1)) >= count);
    stat.shift_last = ((off + CW'(2)) >= count);
    stat.match = (cur.id == pid);
    stat.need_shift = (best != '0) && ((best + CW'(1)) < count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      count <= '0;
      off <= '0;
      best <= '0;
      found <= 1'b0;
      r_status <= ST_OK;
      r_taken_valid <= 1'b0;
      r_taken <= '0;
    end else if (cmd.start) begin
      req <= req_type;
      pid <= process_id;
      in_e <= '{process_id, remaining_in, priority_in, waited_in};
      off <= '0;
      best <= '0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      if (req == REQ_REMOVE) begin
        if (cur.id == pid) begin
          found <= 1'b1;
          best <= off;
        end
      end else if (req == REQ_TICK) begin
        if (cur.waited != 16'hFFFF) mem[slot_of(head, off)].waited <= cur.waited + 16'd1;
      end else if (off == '0 || key < best_key) begin
        best <= off;
        best_key <= key;
        best_e <= cur;
      end
      off <= off + CW'(1);
    end else if (cmd.sel) begin
      off <= best;
    end else if (cmd.shift) begin
      mem[slot_of(head, off)] <= nxt_e;
      off <= off + CW'(1);
    end else if (cmd.finish) begin
      unique case (req) inside
        REQ_ENQ: begin
          r_taken_valid <= 1'b0;
          r_taken <= '0;
          if (count == CW'(DEPTH)) r_status <= ST_FULL;
          else begin
            r_status <= ST_OK;
            mem[slot_of(head, count)] <= in_e;
            count <= count + CW'(1);
          end
        end
        REQ_FIFO, REQ_SHORT, REQ_PRIO: begin
          if (count == '0) begin
            r_status <= ST_EMPTY;
            r_taken_valid <= 1'b0;
            r_taken <= '0;
          end else begin
            r_status <= ST_OK;
            r_taken_valid <= 1'b1;
            r_taken <= best_e;
            if (best == '0) head <= slot_of(head, CW'(1));
            count <= count - CW'(1);
          end
        end
        REQ_REMOVE: begin
          r_taken_valid <= 1'b0;
          r_taken <= '0;
          if (count == '0) r_status <= ST_EMPTY;
          else if (!found) r_status <= ST_NOTFOUND;
          else begin
            r_status <= ST_OK;
            if (best == '0) head <= slot_of(head, CW'(1));
            count <= count - CW'(1);
          end
        end
        default: begin
          r_status <= ST_OK;
          r_taken_valid <= 1'b0;
          r_taken <= '0;
        end
      endcase
    end
  end

  always_comb begin
    r_occupancy = 5'(count);
  end
endmodule
`default_nettype wire

// ===== hdl/rqms_ctrl.sv =====
// ----------------------------------------------------------------------------
// rqms_ctrl
// Sequencer: scan, optional gap close, result commit and output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module rqms_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rqms_pkg::cmd_t       cmd,
  input  wire rqms_pkg::stat_t stat
);
  import rqms_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_SCAN, S_SEL, S_SHIFT, S_FIN} st_t;
  st_t st;

  assign in_ready = (st == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    cmd.start = in_valid && in_ready;
    cmd.scan = (st == S_SCAN);
    cmd.sel = (st == S_SEL);
    cmd.shift = (st == S_SHIFT);
    cmd.finish = (st == S_FIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st)
        S_IDLE: if (cmd.start) st <= S_DEC;
        S_DEC: begin
          if (stat.empty || stat.req == REQ_ENQ || stat.req > REQ_TICK) st <= S_FIN;
          else st <= S_SCAN;
        end
        S_SCAN: begin
          unique case (stat.req)
            REQ_FIFO: st <= S_SEL;
            REQ_REMOVE: begin
              if (stat.match) st <= S_SEL;
              else if (stat.scan_last) st <= S_FIN;
            end
            REQ_TICK: if (stat.scan_last) st <= S_FIN;
            default: if (stat.scan_last) st <= S_SEL;
          endcase
        end
        S_SEL: st <= stat.need_shift ? S_SHIFT : S_FIN;
        S_SHIFT: if (stat.shift_last) st <= S_FIN;
        S_FIN: begin
          st <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ready_queue_with_min_select_unit.sv =====
// ----------------------------------------------------------------------------
// ready_queue_with_min_select_unit
// Ordered process queue with FIFO, remove-by-id, shortest and priority takes.
// ----------------------------------------------------------------------------
// One request is handled at a time. Enqueue, unknown requests and any request
// on an empty queue go from decode straight to commit, and a FIFO take passes
// decode, a single scan and select before commit. Shortest and priority takes,
// removes and ticks walk the held entries one a cycle, and a removal between
// head and tail then closes the gap one entry a cycle. The result is registered
// and the next beat is taken once it has left or while it is being taken.
`default_nettype none
module ready_queue_with_min_select_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  req_type,
  input  wire logic [7:0]  process_id,
  input  wire logic [15:0] remaining_in,
  input  wire logic [7:0]  priority_in,
  input  wire logic [15:0] waited_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic             taken_valid,
  output logic [7:0]       taken_id,
  output logic [15:0]      taken_remaining,
  output logic [7:0]       taken_priority,
  output logic [15:0]      taken_waited,
  output logic [4:0]       occupancy
);
  import rqms_pkg::*;
  cmd_t  cmd;
  stat_t stat;
  slot_t tk;

  rqms_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .cmd, .stat);
  rqms_datapath u_dp (.clk, .rst, .cmd, .stat, .req_type, .process_id,
    .remaining_in, .priority_in, .waited_in, .r_status(status),
    .r_taken_valid(taken_valid), .r_taken(tk), .r_occupancy(occupancy));

  assign taken_id = tk.id;
  assign taken_remaining = tk.remaining;
  assign taken_priority = tk.prio;
  assign taken_waited = tk.waited;
endmodule
`default_nettype wire

// ===== hdl/rqms_checker.sv =====
// ----------------------------------------------------------------------------
// rqms_checker
// Port-level checks for the ready queue.
// ----------------------------------------------------------------------------
`default_nettype none
module rqms_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] status,
  input wire logic       taken_valid,
  input wire logic [4:0] occupancy
);
  import rqms_pkg::*;

  a_occ: assert property (@(posedge clk) disable iff (rst) occupancy <= 5'(DEPTH))
    else $error("occupancy over depth");
  a_tv: assert property (@(posedge clk) disable iff (rst)
    out_valid && taken_valid |-> status == ST_OK)
    else $error("take with bad status");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(occupancy))
    else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat while busy");
endmodule
bind ready_queue_with_min_select_unit rqms_checker u_chk (.clk, .rst, .in_valid,
  .in_ready, .out_valid, .out_ready, .status, .taken_valid, .occupancy);
`default_nettype wire

// ===== verif/ready_queue_with_min_select_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ready_queue_with_min_select_unit_tb
// Drives directed and random scheduler requests through the ready queue and
// checks every result beat against a queue model kept in the bench, under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module ready_queue_with_min_select_unit_tb;
  import rqms_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 530;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  pid;
    logic [15:0] rem;
    logic [7:0]  prio;
    logic [15:0] wait_t;
  } req_beat_t;

  typedef struct packed {
    logic [1:0]  st;
    logic        tv;
    logic [7:0]  tid;
    logic [15:0] trem;
    logic [7:0]  tprio;
    logic [15:0] twait;
    logic [4:0]  occ;
  } rsp_beat_t;

  typedef struct {
    req_beat_t b;
    logic      has_exp;
    rsp_beat_t exp;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [7:0] process_id = '0;
  logic [15:0] remaining_in = '0;
  logic [7:0] priority_in = '0;
  logic [15:0] waited_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic taken_valid;
  logic [7:0] taken_id;
  logic [15:0] taken_remaining;
  logic [7:0] taken_priority;
  logic [15:0] taken_waited;
  logic [4:0] occupancy;

  ready_queue_with_min_select_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // queue model: index 0 is the head
  slot_t     held_q[$];
  rsp_beat_t rsp_q[$];
  rsp_beat_t pinned_q[$];
  logic      pinned_flag_q[$];
  int        in_idle_pct = 0;
  int        out_stall_pct = 0;
  int        mismatches = 0;
  int        wdog = 0;
  bit        done = 0;

  function automatic rsp_beat_t queue_apply(req_beat_t b);
    rsp_beat_t r;
    int pos;
    r = '0;
    r.st = ST_OK;
    case (b.req) inside
      REQ_ENQ: begin
        if (held_q.size() >= DEPTH) r.st = ST_FULL;
        else held_q.push_back('{b.pid, b.rem, b.prio, b.wait_t});
      end
      REQ_FIFO, REQ_SHORT, REQ_PRIO: begin
        if (held_q.size() == 0) r.st = ST_EMPTY;
        else begin
          pos = 0;
          for (int i = 1; i < held_q.size(); i++) begin
            if (b.req == REQ_SHORT && held_q[i].remaining < held_q[pos].remaining)
              pos = i;
            if (b.req == REQ_PRIO && held_q[i].prio < held_q[pos].prio) pos = i;
          end
          r.tv = 1'b1;
          {r.tid, r.trem, r.tprio, r.twait} = held_q[pos];
          held_q.delete(pos);
        end
      end
      REQ_REMOVE: begin
        if (held_q.size() == 0) r.st = ST_EMPTY;
        else begin
          r.st = ST_NOTFOUND;
          foreach (held_q[i]) begin
            if (held_q[i].id == b.pid) begin
              held_q.delete(i);
              r.st = ST_OK;
              break;
            end
          end
        end
      end
      REQ_TICK: begin
        foreach (held_q[i])
          if (held_q[i].waited != 16'hFFFF) held_q[i].waited++;
      end
      default: ;
    endcase
    r.occ = 5'(held_q.size());
    return r;
  endfunction

  task automatic send_beat(req_beat_t b, logic has_exp, rsp_beat_t exp);
    rsp_beat_t p;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {req_type, process_id, remaining_in, priority_in, waited_in} <= b;
    p = queue_apply(b);
    rsp_q.push_back(p);
    pinned_q.push_back(exp);
    pinned_flag_q.push_back(has_exp);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
  endtask

  function automatic req_beat_t rand_beat();
    req_beat_t b;
    int k;
    b.pid = 8'($urandom_range(15));
    if ($urandom_range(9) == 0) b.pid = 8'($urandom);
    b.rem = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20));
    b.prio = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8));
    b.wait_t = ($urandom_range(4) == 0) ? 16'hFFFF - 16'($urandom_range(2))
                                        : 16'($urandom);
    k = $urandom_range(99);
    if (k < 35) b.req = REQ_ENQ;
    else if (k < 48) b.req = REQ_FIFO;
    else if (k < 60) b.req = REQ_REMOVE;
    else if (k < 72) b.req = REQ_SHORT;
    else if (k < 84) b.req = REQ_PRIO;
    else if (k < 96) b.req = REQ_TICK;
    else b.req = 3'($urandom_range(7, 6));
    return b;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    rsp_beat_t got, exp;
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("timeout");
        $display("[FAIL] regression broken");
        $finish;
      end
      if (out_valid && out_ready) begin
        got = {status, taken_valid, taken_id, taken_remaining, taken_priority, taken_waited,
               occupancy};
        if (rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", got);
        end else begin
          exp = rsp_q.pop_front();
          if (pinned_flag_q.pop_front() && pinned_q[0] != exp) begin
            mismatches++;
            if (mismatches <= 10) $display("table row disagrees: %h vs %h", pinned_q[0], exp);
          end
          void'(pinned_q.pop_front());
          if (got !== exp) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch exp st=%0d tv=%0d id=%0d rem=%0d pr=%0d w=%0d occ=%0d",
                        " / got st=%0d tv=%0d id=%0d rem=%0d pr=%0d w=%0d occ=%0d"},
                exp.st, exp.tv, exp.tid, exp.trem, exp.tprio, exp.twait, exp.occ,
                got.st, got.tv, got.tid, got.trem, got.tprio, got.twait, got.occ);
          end
        end
      end
    end
  end

  dir_row_t dir_tab[$];

  task automatic add_row(logic [2:0] rq, logic [7:0] id, logic [15:0] rm, logic [7:0] pr,
                         logic [15:0] wt, logic he, rsp_beat_t ex);
    dir_tab.push_back('{'{rq, id, rm, pr, wt}, he, ex});
  endtask

  initial begin
    int phase;
    add_row(REQ_FIFO, 0, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0});
    add_row(REQ_SHORT, 0, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0});
    add_row(REQ_PRIO, 0, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0});
    add_row(REQ_REMOVE, 3, 0, 0, 0, 1, '{ST_EMPTY, 0, 0, 0, 0, 0, 0});
    add_row(REQ_TICK, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0});
    add_row(3'd6, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 0});
    add_row(REQ_ENQ, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFE, 1, '{ST_OK, 0, 0, 0, 0, 0, 1});
    add_row(REQ_ENQ, 0, 0, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0, 2});
    add_row(REQ_ENQ, 8'h5A, 0, 0, 16'hFFFF, 0, '0);
    add_row(REQ_ENQ, 8'hA5, 16'h8000, 8'h80, 16'h1234, 0, '0);
    add_row(REQ_TICK, 0, 0, 0, 0, 0, '0);
    add_row(REQ_TICK, 0, 0, 0, 0, 0, '0);
    add_row(REQ_SHORT, 0, 0, 0, 0, 0, '0);
    add_row(REQ_PRIO, 0, 0, 0, 0, 0, '0);
    add_row(REQ_REMOVE, 8'h77, 0, 0, 0, 0, '0);
    add_row(REQ_REMOVE, 8'hA5, 0, 0, 0, 0, '0);
    add_row(3'd7, 0, 0, 0, 0, 0, '0);
    add_row(REQ_FIFO, 0, 0, 0, 0, 0, '0);
    for (int i = 0; i < 17; i++) add_row(REQ_ENQ, 8'(i), 16'(i % 3), 8'(5 - i % 4), 0, 0, '0);
    add_row(REQ_PRIO, 0, 0, 0, 0, 0, '0);
    add_row(REQ_REMOVE, 8'd9, 0, 0, 0, 0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) send_beat(dir_tab[i].b, dir_tab[i].has_exp, dir_tab[i].exp);
    drain();
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n * 5) / N_RANDOM;
      in_idle_pct = (phase == 1 || phase == 3) ? 70 : 0;
      out_stall_pct = (phase == 2 || phase == 3) ? 70 : 0;
      if (phase == 4) begin
        in_idle_pct = 37;
        out_stall_pct = 37;
      end
      send_beat(rand_beat(), 0, '0);
    end
    drain();
    repeat (100) @(posedge clk);
    done = 1;
  end

  initial begin
    wait (done);
    if (mismatches == 0 && rsp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
